@@ design/cts_pkg.sv @@
// Shared types and constants for the column texel stepper.
`default_nettype none

package cts_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int ACC_W      = 48;                   // coordinate accumulator, no wrap in 2048 steps
   localparam int WORD_W     = 32;
   localparam int WHOLE_W    = ACC_W - FRAC_BITS;
   localparam int COORD_W    = 12;
   localparam int ROW_W      = 11;
   localparam int CNT_W      = 12;
   localparam int LEN_W      = 11;
   localparam int CY_W       = 28;
   localparam int IDX_W      = 16;
   localparam int DIFF_W     = ROW_W + FRAC_BITS + 2;
   localparam int PROD_W     = DIFF_W + WORD_W;
   localparam int MAG_W      = 17;                   // integer part magnitude fed to the remainder unit
   localparam int REM_W      = LEN_W + 1;
   localparam int DIV_CNT_W  = $clog2(MAG_W);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = CY_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_W = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_H = 2'd2;

   localparam logic [COORD_W-1:0] RESET_SCREEN_W = 12'd320;
   localparam logic [COORD_W-1:0] RESET_SCREEN_H = 12'd200;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef enum logic [1:0] {
      MODE_MASK     = 2'd0,
      MODE_NOHEIGHT = 2'd1,
      MODE_MODULO   = 2'd2
   } wrap_mode_type;

   typedef struct packed {
      logic                      cmd;
      logic signed [COORD_W-1:0] column_x;
      logic signed [COORD_W-1:0] row_top;
      logic signed [COORD_W-1:0] row_bottom;
      logic signed [WORD_W-1:0]  texture_mid;
      logic signed [WORD_W-1:0]  frac_step;
      logic [LEN_W-1:0]          source_length;
      logic [LEN_W-1:0]          texture_height;
   } req_type;

   typedef struct packed {
      logic signed [IDX_W-1:0] texel_index;
      logic [ROW_W-1:0]        screen_row;
      logic                    last_pixel;
   } rsp_type;

   typedef struct packed {
      logic start_load;
      logic cancel;
      logic mul;
      logic sum;
      logic fix;
      logic step;
      logic div_load;
      logic div_iter;
      logic div_store;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic start_ok;
      logic active;
      logic step_wraps;
      logic start_wraps;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ design/cts_ctrl.sv @@
// Sequencer for the column texel stepper: start setup, pixel steps, serial wrap.
`default_nettype none

module cts_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_cmd,
   output logic                    req_ready,
   input  wire cts_pkg::dp_stat_type stat,
   output cts_pkg::dp_cmd_type     cmd
);
   import cts_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_FIX,
      ST_DIV
   } state_type;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MAG_W - 1);

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 accept;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = (state_ff == ST_IDLE) && stat.out_free;
      accept    = req_valid && req_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_START) begin
                  if (stat.start_ok) begin
                     cmd.start_load = 1'b1;
                     state_in       = ST_MUL;
                  end else begin
                     cmd.cancel = 1'b1;
                  end
               end else if (stat.active) begin
                  cmd.step = 1'b1;
                  if (stat.step_wraps) begin
                     cmd.div_load = 1'b1;
                     cnt_in       = '0;
                     state_in     = ST_DIV;
                  end
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix = 1'b1;
            if (stat.start_wraps) begin
               cmd.div_load = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_iter = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cmd.div_store = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ design/cts_dp.sv @@
// Datapath: column registers, start multiply, coordinate stepping, serial remainder.
`default_nettype none

module cts_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cts_pkg::req_type              req,
   output cts_pkg::rsp_type                   rsp,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic signed [cts_pkg::CY_W-1:0]    center_y_frac,
   input  wire logic [cts_pkg::COORD_W-1:0]   screen_width,
   input  wire logic [cts_pkg::COORD_W-1:0]   screen_height,
   input  wire cts_pkg::dp_cmd_type           cmd,
   output cts_pkg::dp_stat_type               stat
);
   import cts_pkg::*;

   localparam logic signed [WHOLE_W-1:0] MINUS_ONE = '1;

   logic signed [ACC_W-1:0]  frac_acc_ff;
   logic signed [WORD_W-1:0] step_ff;
   logic signed [WORD_W-1:0] mid_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [WORD_W-1:0] prod_ff;
   logic [CNT_W-1:0]         pixels_left_ff;
   logic [ROW_W-1:0]         row_now_ff;
   wrap_mode_type            mode_ff;
   logic [LEN_W-1:0]         len_ff;
   logic [LEN_W-1:0]         height_ff;
   logic [LEN_W-1:0]         rem_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic                     neg_ff;
   logic [FRAC_BITS-1:0]     lo_ff;
   rsp_type                  rsp_ff;
   logic                     rsp_valid_ff;

   logic signed [ACC_W-1:0]   frac_sum;
   logic signed [WHOLE_W-1:0] whole;
   logic signed [WHOLE_W-1:0] sum_whole;
   logic signed [PROD_W-1:0]  prod_full;
   logic [LEN_W-1:0]          len_m1;
   logic [IDX_W-1:0]          idx;
   logic                      wrap_on;
   logic                      bad_column;
   wrap_mode_type             mode_new;
   logic signed [ACC_W-1:0]   div_src;
   logic signed [WHOLE_W-1:0] div_whole;
   logic [REM_W-1:0]          rem_shift;
   logic [LEN_W-1:0]          rem_next;
   logic [LEN_W-1:0]          res_whole;

   assign frac_sum  = frac_acc_ff + {{(ACC_W-WORD_W){step_ff[WORD_W-1]}}, step_ff};
   assign whole     = frac_acc_ff[ACC_W-1:FRAC_BITS];
   assign sum_whole = frac_sum[ACC_W-1:FRAC_BITS];
   assign prod_full = PROD_W'(diff_ff) * PROD_W'(step_ff);
   assign len_m1    = len_ff - 1'b1;
   assign wrap_on   = (mode_ff == MODE_MODULO) && (height_ff != '0);

   always_comb begin
      unique case (mode_ff)
         MODE_MASK:     idx = whole[IDX_W-1:0] & IDX_W'(len_m1);
         MODE_NOHEIGHT: idx = whole[IDX_W-1:0];
         MODE_MODULO: begin
            if (whole < MINUS_ONE)
               idx = '1;
            else if (whole > $signed(WHOLE_W'(len_ff)))
               idx = IDX_W'(len_ff);
            else
               idx = whole[IDX_W-1:0];
         end
         default:       idx = whole[IDX_W-1:0];
      endcase
   end

   always_comb begin
      bad_column = (req.row_bottom < req.row_top) ||
                   req.column_x[COORD_W-1] ||
                   ($unsigned(req.column_x) >= screen_width) ||
                   req.row_top[COORD_W-1] ||
                   (!req.row_bottom[COORD_W-1] &&
                    ($unsigned(req.row_bottom) >= screen_height));
      if (req.source_length == '0)
         mode_new = MODE_NOHEIGHT;
      else if ((req.source_length & (req.source_length - 1'b1)) == '0)
         mode_new = MODE_MASK;
      else
         mode_new = MODE_MODULO;
   end

   // remainder unit: integer part modulo texture height, fraction bits ride along
   always_comb begin
      div_src   = cmd.step ? frac_sum : frac_acc_ff;
      div_whole = div_src[ACC_W-1:FRAC_BITS];
      rem_shift = {rem_ff, mag_ff[MAG_W-1]};
      if (rem_shift >= REM_W'(height_ff))
         rem_next = LEN_W'(rem_shift - REM_W'(height_ff));
      else
         rem_next = rem_shift[LEN_W-1:0];
      // floor modulo for a negative coordinate
      if (neg_ff && (rem_next != '0))
         res_whole = height_ff - rem_next;
      else
         res_whole = rem_next;
   end

   always_comb begin
      stat.out_free    = !rsp_valid_ff || rsp_ready;
      stat.start_ok    = !bad_column;
      stat.active      = (pixels_left_ff != '0);
      stat.step_wraps  = wrap_on && (sum_whole >= $signed(WHOLE_W'(height_ff)));
      stat.start_wraps = wrap_on;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pixels_left_ff <= '0;
         mode_ff        <= MODE_MASK;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.start_load) begin
            pixels_left_ff <= CNT_W'(req.row_bottom - req.row_top) + CNT_W'(1);
            mode_ff        <= mode_new;
         end else if (cmd.cancel) begin
            pixels_left_ff <= '0;
         end else if (cmd.step) begin
            pixels_left_ff <= pixels_left_ff - 1'b1;
         end
         if (cmd.step)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.start_load) begin
         row_now_ff <= req.row_top[ROW_W-1:0];
         mid_ff     <= req.texture_mid;
         step_ff    <= req.frac_step;
         len_ff     <= req.source_length;
         height_ff  <= req.texture_height;
         diff_ff    <= $signed({2'b00, req.row_top[ROW_W-1:0], {FRAC_BITS{1'b0}}}) -
                       DIFF_W'(center_y_frac);
      end else if (cmd.step) begin
         row_now_ff <= row_now_ff + 1'b1;
      end

      if (cmd.mul)
         prod_ff <= prod_full[FRAC_BITS+WORD_W-1:FRAC_BITS];

      if (cmd.sum)
         frac_acc_ff <= ACC_W'(mid_ff) + ACC_W'(prod_ff);
      else if (cmd.fix && (mode_ff == MODE_NOHEIGHT) && frac_acc_ff[ACC_W-1])
         frac_acc_ff <= frac_sum;
      else if (cmd.step)
         frac_acc_ff <= frac_sum;
      else if (cmd.div_store)
         frac_acc_ff <= ACC_W'({res_whole, lo_ff});

      if (cmd.step) begin
         rsp_ff.texel_index <= idx;
         rsp_ff.screen_row  <= row_now_ff;
         rsp_ff.last_pixel  <= (pixels_left_ff == CNT_W'(1));
      end

      if (cmd.div_load) begin
         neg_ff <= div_src[ACC_W-1];
         mag_ff <= div_src[ACC_W-1] ? MAG_W'(-div_whole) : MAG_W'(div_whole);
         lo_ff  <= div_src[FRAC_BITS-1:0];
         rem_ff <= '0;
      end else if (cmd.div_iter) begin
         rem_ff <= rem_next;
         mag_ff <= {mag_ff[MAG_W-2:0], 1'b0};
      end
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ design/column_texel_stepper.sv @@
// Column texel stepper: a start request sets up one screen column (start coordinate
// mid + ((top<<16) - center_y) * step >> 16 and a wrap mode chosen from the source
// length); each step request while pixels remain then returns one texel index, its
// screen row and a last-pixel flag. When a modulo-wrapped coordinate reaches the
// texture height, the step is followed by a wrap through a one-bit-per-cycle remainder
// unit. A start goes through load, multiply, add and fixup, then the same remainder
// pass for a modulo column with a nonzero height; a rejected start clears the column.
// A request is taken while idle and the response register is free or being emptied.
`default_nettype none

module column_texel_stepper (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [cts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [cts_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire cts_pkg::req_type                req,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output cts_pkg::rsp_type                     rsp
);
   import cts_pkg::*;

   logic signed [CY_W-1:0] center_y_ff;
   logic [COORD_W-1:0]     screen_w_ff;
   logic [COORD_W-1:0]     screen_h_ff;
   dp_cmd_type             dp_cmd;
   dp_stat_type            dp_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_y_ff <= '0;
         screen_w_ff <= RESET_SCREEN_W;
         screen_h_ff <= RESET_SCREEN_H;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_SCREEN_W: screen_w_ff <= csr_wdata[COORD_W-1:0];
            CSR_SCREEN_H: screen_h_ff <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   cts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req.cmd),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   cts_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .center_y_frac (center_y_ff),
      .screen_width  (screen_w_ff),
      .screen_height (screen_h_ff),
      .cmd           (dp_cmd),
      .stat          (dp_stat)
   );

endmodule

`default_nettype wire

@@ design/cts_checker.sv @@
// Port-level checks for the column texel stepper, bound to the top level.
`default_nettype none

module cts_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire cts_pkg::req_type                req,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire cts_pkg::rsp_type                rsp
);
   import cts_pkg::*;

   logic req_take;
   assign req_take = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a new response only comes from an accepted step request
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid && !rsp_ready) |->
         $past(req_take && (req.cmd == CMD_STEP)))
      else $error("response without a step request");

   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      req_take && (req.cmd == CMD_START) |=> !rsp_valid || $stable(rsp))
      else $error("start request produced a response");

   // a stalled response blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

endmodule

bind column_texel_stepper cts_checker u_cts_checker (.*);

`default_nettype wire
